### sv/wnmc_pkg.sv
// Shared constants, types and codes of the word near-match checker.
package wnmc_pkg;

	// Storage and field widths
	localparam int MAX_CHARS = 32;
	localparam int ADDR_W    = $clog2(MAX_CHARS);
	localparam int LEN_W     = $clog2(MAX_CHARS + 1);
	localparam int MISM_W    = (LEN_W > 6) ? LEN_W : 6;
	localparam int CHAR_W    = 8;
	localparam int CODE_NUM  = 1 << CHAR_W;
	localparam int LIMIT_W   = 6;
	localparam int MISM_SAT  = 63;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam logic LIMIT_IDX = 1'b0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd3;

	// Operation codes
	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_DICT  = 1'b1;

	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [LIMIT_W-1:0] limit_t;
	typedef logic [1:0]         reason_t;

	// Match reason codes
	localparam reason_t REASON_NONE     = 2'd0;
	localparam reason_t REASON_SUBSEQ   = 2'd1;
	localparam reason_t REASON_ANAGRAM  = 2'd2;
	localparam reason_t REASON_MISMATCH = 2'd3;

	// Engine result handed to the output stage
	typedef struct packed {
		logic       done;
		logic       exact;
		logic       suggest;
		reason_t    reason;
		logic [5:0] mism;
	} eng_res_t;

endpackage

### sv/word_near_match_checker_top.sv
// Top level of the word near-match checker: loading, configuration, output register.
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_ready    operation, char_code, last_char
//  output    out        out_valid / out_ready  exact_match, suggest, match_reason,
//                                              mismatch_count, too_long
//  config    in         APB psel/penable       paddr, pwdata, prdata
//
// A character request that ends no dictionary word does not start the engine. A dictionary word end
// runs the mismatch count over the Q query characters, then the subsequence walk over the
// longer word's L characters when lengths differ by one, or the anagram tally when lengths
// are equal, and then hands the result over.
// in_ready is low meanwhile and while a finished result waits for the output register.
// Reset clears lengths and flags and sets the limit to 3.
module word_near_match_checker_top
	import wnmc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               exact_match,
	output logic               suggest,
	output logic [1:0]         match_reason,
	output logic [5:0]         mismatch_count,
	output logic               too_long
);

	len_t     qlen_q;
	len_t     dlen_q;
	logic     qdone_q;
	logic     ovf_q;
	logic     dover_q;
	limit_t   limit_q;
	logic     out_valid_q;
	logic     exact_q;
	logic     suggest_q;
	reason_t  reason_q;
	logic [5:0] mism_q;
	logic     too_long_q;

	logic     in_acc;
	logic     q_acc;
	logic     d_acc;
	len_t     q_eff_len;
	logic     q_wr_en;
	logic     d_wr_en;
	logic     busy;
	logic     start;
	logic     take;
	eng_res_t res;
	logic     q_rd_en;
	addr_t    q_rd_addr;
	char_t    q_rd_data;
	logic     d_rd_en;
	addr_t    d_rd_addr;
	char_t    d_rd_data;
	logic     cfg_wr;

	// Request decode
	always_comb begin
		in_ready  = !busy;
		in_acc    = in_valid && in_ready;
		q_acc     = in_acc && (operation == OP_QUERY);
		d_acc     = in_acc && (operation == OP_DICT);
		q_eff_len = qdone_q ? '0 : qlen_q;
		q_wr_en   = q_acc && (q_eff_len < len_t'(MAX_CHARS));
		d_wr_en   = d_acc && (dlen_q < len_t'(MAX_CHARS));
		start     = d_acc && last_char;
		take      = res.done && (!out_valid_q || out_ready);
	end

	// Configuration port
	always_comb begin
		pready = 1'b1;
		cfg_wr = psel && penable && pwrite && (paddr[2] == LIMIT_IDX);
		prdata = (paddr[2] == LIMIT_IDX) ? 32'(limit_q) : 32'd0;
	end

	wnmc_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_CHARS)
	) u_query_ram (
		.clk    (clk),
		.wr_en  (q_wr_en),
		.wr_addr(q_eff_len[ADDR_W-1:0]),
		.wr_data(char_code),
		.rd_en  (q_rd_en),
		.rd_addr(q_rd_addr),
		.rd_data(q_rd_data)
	);

	wnmc_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_CHARS)
	) u_dict_ram (
		.clk    (clk),
		.wr_en  (d_wr_en),
		.wr_addr(dlen_q[ADDR_W-1:0]),
		.wr_data(char_code),
		.rd_en  (d_rd_en),
		.rd_addr(d_rd_addr),
		.rd_data(d_rd_data)
	);

	wnmc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.qlen     (qlen_q),
		.dlen     (dlen_q),
		.limit    (limit_q),
		.take     (take),
		.busy     (busy),
		.res      (res),
		.q_rd_en  (q_rd_en),
		.q_rd_addr(q_rd_addr),
		.q_rd_data(q_rd_data),
		.d_rd_en  (d_rd_en),
		.d_rd_addr(d_rd_addr),
		.d_rd_data(d_rd_data)
	);

	// Word lengths, flags and limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q  <= '0;
			dlen_q  <= '0;
			qdone_q <= 1'b0;
			ovf_q   <= 1'b0;
			dover_q <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cfg_wr) begin
				limit_q <= pwdata[LIMIT_W-1:0];
			end
			if (q_acc) begin
				// a query character after a finished query starts a new one
				if (q_wr_en) begin
					qlen_q <= q_eff_len + 1'b1;
					ovf_q  <= qdone_q ? 1'b0 : ovf_q;
				end else begin
					qlen_q <= q_eff_len;
					ovf_q  <= 1'b1;
				end
				qdone_q <= last_char;
			end
			if (d_acc) begin
				if (d_wr_en) begin
					dlen_q <= dlen_q + 1'b1;
				end else begin
					dover_q <= 1'b1;
				end
			end
			if (take) begin
				dlen_q  <= '0;
				dover_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold result payload
	always_ff @(posedge clk) begin
		if (take) begin
			exact_q    <= res.exact;
			suggest_q  <= res.suggest;
			reason_q   <= res.reason;
			mism_q     <= res.mism;
			too_long_q <= ovf_q || dover_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign exact_match    = exact_q;
	assign suggest        = suggest_q;
	assign match_reason   = reason_q;
	assign mismatch_count = mism_q;
	assign too_long       = too_long_q;

endmodule

### sv/wnmc_ram.sv
// Generic single-port-write, registered-read RAM.
module wnmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, held when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/wnmc_engine.sv
// Word-end sequencer: mismatch count, subsequence walk and anagram tally.
module wnmc_engine
	import wnmc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  len_t     qlen,
	input  len_t     dlen,
	input  limit_t   limit,
	input  logic     take,
	output logic     busy,
	output eng_res_t res,
	output logic     q_rd_en,
	output addr_t    q_rd_addr,
	input  char_t    q_rd_data,
	output logic     d_rd_en,
	output addr_t    d_rd_addr,
	input  char_t    d_rd_data
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_MM_RD   = 4'd1;
	localparam logic [3:0] ST_MM_CMP  = 4'd2;
	localparam logic [3:0] ST_SUB_RD  = 4'd3;
	localparam logic [3:0] ST_SUB_CMP = 4'd4;
	localparam logic [3:0] ST_ANA_RD  = 4'd5;
	localparam logic [3:0] ST_ANA_KEY = 4'd6;
	localparam logic [3:0] ST_ANA_UPD = 4'd7;
	localparam logic [3:0] ST_DONE    = 4'd8;

	logic [3:0]        state_q;
	len_t              i_q;
	len_t              j_q;
	logic [MISM_W-1:0] mism_q;
	logic              pass_q;
	logic [CODE_NUM-1:0] cnt_vld_q;
	logic              exact_q;
	logic              suggest_q;
	reason_t           reason_q;

	logic  ch_eq;
	logic  dict_long;
	len_t  short_len;
	len_t  long_len;
	char_t key;
	len_t  cnt_rd_data;
	len_t  cnt_cur;
	logic  cnt_rd_en;
	logic  cnt_wr_en;
	len_t  cnt_wr_data;
	logic  below_limit;
	logic  exact_now;
	logic  off_by_one;
	logic  sub_end;

	// Shared compare unit and walk bounds
	always_comb begin
		ch_eq       = (q_rd_data == d_rd_data);
		dict_long   = (dlen > qlen);
		short_len   = dict_long ? qlen : dlen;
		long_len    = dict_long ? dlen : qlen;
		key         = pass_q ? d_rd_data : q_rd_data;
		cnt_cur     = cnt_vld_q[key] ? cnt_rd_data : '0;
		below_limit = (mism_q < MISM_W'(limit));
		exact_now   = (qlen == dlen) && (mism_q == '0);
		off_by_one  = ((LEN_W+1)'(dlen) == (LEN_W+1)'(qlen) + 1'b1) ||
			((LEN_W+1)'(qlen) == (LEN_W+1)'(dlen) + 1'b1);
		sub_end     = (i_q == short_len) || (j_q == long_len);
	end

	// Drive store and tally read ports
	always_comb begin
		q_rd_en   = 1'b0;
		d_rd_en   = 1'b0;
		q_rd_addr = i_q[ADDR_W-1:0];
		d_rd_addr = i_q[ADDR_W-1:0];
		cnt_rd_en = 1'b0;
		unique case (state_q)
			ST_MM_RD: begin
				q_rd_en = (i_q != qlen);
				d_rd_en = (i_q != qlen);
			end
			ST_SUB_RD: begin
				q_rd_en   = !sub_end;
				d_rd_en   = !sub_end;
				q_rd_addr = dict_long ? i_q[ADDR_W-1:0] : j_q[ADDR_W-1:0];
				d_rd_addr = dict_long ? j_q[ADDR_W-1:0] : i_q[ADDR_W-1:0];
			end
			ST_ANA_RD: begin
				q_rd_en = (i_q != qlen) && !pass_q;
				d_rd_en = (i_q != qlen) && pass_q;
			end
			ST_ANA_KEY: begin
				cnt_rd_en = 1'b1;
			end
			default: begin
			end
		endcase
		cnt_wr_en   = (state_q == ST_ANA_UPD) && (!pass_q || (cnt_cur != '0));
		cnt_wr_data = pass_q ? len_t'(cnt_cur - 1'b1) : len_t'(cnt_cur + 1'b1);
	end

	// Character tally: query adds, dictionary word removes
	wnmc_ram #(
		.WIDTH(LEN_W),
		.DEPTH(CODE_NUM)
	) u_cnt_ram (
		.clk    (clk),
		.wr_en  (cnt_wr_en),
		.wr_addr(key),
		.wr_data(cnt_wr_data),
		.rd_en  (cnt_rd_en),
		.rd_addr(key),
		.rd_data(cnt_rd_data)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			mism_q    <= '0;
			pass_q    <= 1'b0;
			cnt_vld_q <= '0;
			exact_q   <= 1'b0;
			suggest_q <= 1'b0;
			reason_q  <= REASON_NONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						i_q     <= '0;
						mism_q  <= '0;
						state_q <= ST_MM_RD;
					end
				end
				ST_MM_RD: begin
					if (i_q == qlen) begin
						exact_q   <= exact_now;
						suggest_q <= 1'b0;
						reason_q  <= REASON_NONE;
						i_q       <= '0;
						j_q       <= '0;
						pass_q    <= 1'b0;
						if (exact_now) begin
							state_q <= ST_DONE;
						end else if (off_by_one) begin
							state_q <= ST_SUB_RD;
						end else if (dlen == qlen) begin
							state_q <= ST_ANA_RD;
						end else begin
							suggest_q <= (dlen < qlen) && below_limit;
							reason_q  <= ((dlen < qlen) && below_limit) ?
								REASON_MISMATCH : REASON_NONE;
							state_q   <= ST_DONE;
						end
					end else begin
						state_q <= ST_MM_CMP;
					end
				end
				ST_MM_CMP: begin
					if ((i_q >= dlen) || !ch_eq) begin
						mism_q <= mism_q + 1'b1;
					end
					i_q     <= i_q + 1'b1;
					state_q <= ST_MM_RD;
				end
				ST_SUB_RD: begin
					if (sub_end) begin
						suggest_q <= (i_q == short_len);
						reason_q  <= (i_q == short_len) ? REASON_SUBSEQ : REASON_NONE;
						state_q   <= ST_DONE;
					end else begin
						state_q <= ST_SUB_CMP;
					end
				end
				ST_SUB_CMP: begin
					if (ch_eq) begin
						i_q <= i_q + 1'b1;
					end
					j_q     <= j_q + 1'b1;
					state_q <= ST_SUB_RD;
				end
				ST_ANA_RD: begin
					if (i_q == qlen) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							i_q    <= '0;
						end else begin
							suggest_q <= 1'b1;
							reason_q  <= REASON_ANAGRAM;
							cnt_vld_q <= '0;
							state_q   <= ST_DONE;
						end
					end else begin
						state_q <= ST_ANA_KEY;
					end
				end
				ST_ANA_KEY: begin
					state_q <= ST_ANA_UPD;
				end
				ST_ANA_UPD: begin
					if (pass_q && (cnt_cur == '0)) begin
						// Dictionary word holds a character the query lacks
						suggest_q <= below_limit;
						reason_q  <= below_limit ? REASON_MISMATCH : REASON_NONE;
						cnt_vld_q <= '0;
						state_q   <= ST_DONE;
					end else begin
						cnt_vld_q[key] <= 1'b1;
						i_q            <= i_q + 1'b1;
						state_q        <= ST_ANA_RD;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result out, saturating the mismatch count
	always_comb begin
		busy         = (state_q != ST_IDLE);
		res.done     = (state_q == ST_DONE);
		res.exact    = exact_q;
		res.suggest  = suggest_q;
		res.reason   = reason_q;
		res.mism     = (mism_q > MISM_W'(MISM_SAT)) ? 6'd63 : mism_q[5:0];
	end

	a_exact_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.done && res.exact |-> !res.suggest && (res.mism == 6'd0))
		else $error("exact match carries a suggestion or mismatches");

	a_reason_agrees: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (res.suggest == (res.reason != REASON_NONE)))
		else $error("suggest flag and reason disagree");

	a_sub_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUB_CMP |-> (i_q < short_len) && (j_q < long_len))
		else $error("subsequence walk left the stored words");

	a_ana_lengths: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ANA_UPD |-> (qlen == dlen) && (i_q < qlen))
		else $error("anagram tally with unequal lengths");

	a_tally_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (cnt_vld_q == '0))
		else $error("character tally not cleared between words");

endmodule

### tb/word_match_monitor.sv
// Checker for the word near-match checker: predicts each word verdict and compares results.
module word_match_monitor
	import wnmc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               operation,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               exact_match,
	input  logic               suggest,
	input  logic [1:0]         match_reason,
	input  logic [5:0]         mismatch_count,
	input  logic               too_long,
	output int                 failures,
	output int                 words_due
);

	typedef struct packed {
		logic       exact;
		logic       suggest;
		reason_t    reason;
		logic [5:0] mism;
		logic       too_long;
	} verdict_t;

	char_t    query_chars [MAX_CHARS];
	char_t    dict_chars  [MAX_CHARS];
	int       query_len;
	int       dict_len;
	bit       query_closed;
	bit       query_over;
	bit       dict_over;
	limit_t   limit;
	verdict_t verdicts_due [$];
	int       reported;

	function automatic string show(input verdict_t v);
		return $sformatf("exact=%0b suggest=%0b reason=%0d mism=%0d too_long=%0b",
			v.exact, v.suggest, v.reason, v.mism, v.too_long);
	endfunction

	// Count a failure; print only the first few
	task automatic flag(input string msg);
		failures++;
		if (reported < 10) begin
			reported++;
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	// True when every char of the short word appears in order in the long one
	function automatic bit in_order(input char_t s [MAX_CHARS], input int ls,
			input char_t l [MAX_CHARS], input int ll);
		int i;
		int j;
		i = 0;
		for (j = 0; j < ll && i < ls; j++)
			if (s[i] == l[j])
				i++;
		return i == ls;
	endfunction

	// One-to-one letter tally of the stored query against the stored word
	function automatic bit same_letters();
		int tally [CODE_NUM];
		int i;
		if (query_len != dict_len)
			return 1'b0;
		for (i = 0; i < CODE_NUM; i++)
			tally[i] = 0;
		for (i = 0; i < query_len; i++) begin
			tally[query_chars[i]]++;
			tally[dict_chars[i]]--;
		end
		for (i = 0; i < CODE_NUM; i++)
			if (tally[i] != 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// Apply one accepted request; at a word end, queue the verdict it must produce
	task automatic take_request(input logic op, input char_t ch, input logic last);
		verdict_t v;
		int       miss;
		int       gap;
		int       i;
		bit       hit;
		if (op == OP_QUERY) begin
			if (query_closed) begin
				query_len = 0;
				query_over = 1'b0;
				query_closed = 1'b0;
			end
			if (query_len < MAX_CHARS) begin
				query_chars[query_len] = ch;
				query_len++;
			end else begin
				query_over = 1'b1;
			end
			if (last)
				query_closed = 1'b1;
		end else begin
			if (dict_len < MAX_CHARS) begin
				dict_chars[dict_len] = ch;
				dict_len++;
			end else begin
				dict_over = 1'b1;
			end
			if (last) begin
				miss = 0;
				for (i = 0; i < query_len; i++)
					if (i >= dict_len || query_chars[i] != dict_chars[i])
						miss++;
				v = '0;
				v.reason = REASON_NONE;
				v.exact = (query_len == dict_len) && (miss == 0);
				if (!v.exact) begin
					gap = (dict_len > query_len) ? dict_len - query_len : query_len - dict_len;
					if (gap == 1) begin
						hit = (dict_len > query_len)
							? in_order(query_chars, query_len, dict_chars, dict_len)
							: in_order(dict_chars, dict_len, query_chars, query_len);
						if (hit) begin
							v.suggest = 1'b1;
							v.reason = REASON_SUBSEQ;
						end
					end else if (dict_len <= query_len) begin
						if (same_letters()) begin
							v.suggest = 1'b1;
							v.reason = REASON_ANAGRAM;
						end else if (miss < int'(limit)) begin
							v.suggest = 1'b1;
							v.reason = REASON_MISMATCH;
						end
					end
				end
				v.mism = (miss > MISM_SAT) ? 6'(MISM_SAT) : 6'(miss);
				v.too_long = query_over || dict_over;
				verdicts_due.push_back(v);
				dict_len = 0;
				dict_over = 1'b0;
			end
		end
	endtask

	// Compare one accepted result against the oldest pending verdict
	task automatic check_verdict();
		verdict_t want;
		verdict_t got;
		got = {exact_match, suggest, match_reason, mismatch_count, too_long};
		if (verdicts_due.size() == 0) begin
			flag($sformatf("result with no word pending: %s", show(got)));
		end else begin
			want = verdicts_due.pop_front();
			if (got !== want)
				flag($sformatf("verdict mismatch: expected %s, got %s", show(want), show(got)));
		end
	endtask

	// Track requests, results and limit accesses at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_len = 0;
			dict_len = 0;
			query_closed = 1'b0;
			query_over = 1'b0;
			dict_over = 1'b0;
			limit = LIMIT_RESET;
			verdicts_due.delete();
			failures = 0;
			reported = 0;
			words_due = 0;
		end else begin
			if (out_valid && out_ready)
				check_verdict();
			if (in_valid && in_ready)
				take_request(operation, char_code, last_char);
			if (psel && penable && pready && paddr[PADDR_W-1:2] == LIMIT_IDX) begin
				if (pwrite)
					limit = pwdata[LIMIT_W-1:0];
				else if (prdata[LIMIT_W-1:0] !== limit)
					flag($sformatf("limit read: expected %0d, got %0d",
						limit, prdata[LIMIT_W-1:0]));
			end
			words_due = verdicts_due.size();
		end
	end

endmodule

### tb/tb.sv
// Testbench top: drives characters and limit settings into the checker and reports the verdict.
module tb;
	import wnmc_pkg::*;

	typedef enum {COPY, DROP_ONE, ADD_ONE, ALTER, SHUFFLE, CUT, FRESH, GROW} edit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               operation = OP_QUERY;
	logic [7:0]         char_code = '0;
	logic               last_char = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               exact_match;
	logic               suggest;
	logic [1:0]         match_reason;
	logic [5:0]         mismatch_count;
	logic               too_long;

	int    failures;
	int    words_due;
	bit    idling = 1'b1;
	int    stall_left = 0;
	int    requests_sent = 0;
	char_t query_word [$];

	// Directed requests: {operation, char, last}
	logic [9:0] opening [24] = '{
		{OP_DICT, 8'h61, 1'b0}, {OP_DICT, 8'h62, 1'b1},
		{OP_DICT, 8'h61, 1'b1},
		{OP_QUERY, 8'h00, 1'b0}, {OP_QUERY, 8'hFF, 1'b0}, {OP_QUERY, 8'h63, 1'b1},
		{OP_DICT, 8'h00, 1'b0}, {OP_DICT, 8'hFF, 1'b0}, {OP_DICT, 8'h63, 1'b1},
		{OP_DICT, 8'h63, 1'b0}, {OP_DICT, 8'hFF, 1'b0}, {OP_DICT, 8'h00, 1'b1},
		{OP_DICT, 8'h00, 1'b0}, {OP_DICT, 8'h63, 1'b1},
		{OP_DICT, 8'h00, 1'b0}, {OP_DICT, 8'h78, 1'b0}, {OP_DICT, 8'h63, 1'b1},
		{OP_DICT, 8'h00, 1'b0}, {OP_DICT, 8'hFF, 1'b0}, {OP_DICT, 8'h63, 1'b0},
		{OP_DICT, 8'h64, 1'b1},
		{OP_DICT, 8'h7A, 1'b0}, {OP_DICT, 8'h7A, 1'b0}, {OP_DICT, 8'h7A, 1'b1}
	};

	word_near_match_checker_top dut (.*);

	word_match_monitor watch (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall results in random bursts while idling is on
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idling && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one request, with an optional gap first, and wait for it to be taken
	task automatic send_char(input logic op, input char_t ch, input logic last);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		char_code <= ch;
		last_char <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic send_word(input logic op, input char_t w [$]);
		int i;
		for (i = 0; i < w.size(); i++)
			send_char(op, w[i], i == w.size() - 1);
	endtask

	// Mostly a small alphabet so near matches happen; sometimes any byte
	function automatic char_t pick_char(input bit wide);
		return wide ? char_t'($urandom_range(0, 255)) : char_t'(8'h61 + $urandom_range(0, 3));
	endfunction

	task automatic send_query();
		int n;
		bit wide;
		wide = ($urandom_range(0, 3) == 0);
		n = ($urandom_range(0, 14) == 0) ? $urandom_range(MAX_CHARS - 2, MAX_CHARS + 4)
			: $urandom_range(1, 8);
		query_word.delete();
		repeat (n) query_word.push_back(pick_char(wide));
		send_word(OP_QUERY, query_word);
	endtask

	// Derive a dictionary word from the current query by one kind of edit
	task automatic send_candidate();
		char_t w [$];
		char_t t;
		edit_t how;
		int    i;
		int    j;
		int    n;
		bit    wide;
		w = query_word;
		wide = ($urandom_range(0, 3) == 0);
		how = edit_t'($urandom_range(0, 7));
		case (how)
			COPY: ;
			DROP_ONE: if (w.size() > 1) w.delete($urandom_range(0, w.size() - 1));
			ADD_ONE: w.insert($urandom_range(0, w.size()), pick_char(wide));
			ALTER: repeat ($urandom_range(1, 4)) w[$urandom_range(0, w.size() - 1)] = pick_char(wide);
			SHUFFLE: begin
				for (i = w.size() - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = w[i];
					w[i] = w[j];
					w[j] = t;
				end
			end
			CUT: begin
				if (w.size() > 1) begin
					n = $urandom_range(1, w.size() - 1);
					while (w.size() > n)
						void'(w.pop_back());
				end
			end
			FRESH: begin
				w.delete();
				repeat ($urandom_range(1, 10)) w.push_back(pick_char(wide));
			end
			default: begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_CHARS + 1, MAX_CHARS + 3)
					: w.size() + $urandom_range(2, 5);
				while (w.size() < n)
					w.push_back(pick_char(wide));
			end
		endcase
		if (w.size() == 0)
			w.push_back(pick_char(wide));
		send_word(OP_DICT, w);
	endtask

	// Random requests of any kind, including broken words and interleaving
	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_char(logic'($urandom_range(0, 1)), char_t'($urandom_range(0, 255)),
				$urandom_range(0, 3) == 0);
	endtask

	// One APB transfer, setup and access phases, on the limit register
	task automatic apb_access(input logic wr, input limit_t value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PADDR_W'({LIMIT_IDX, 2'b00});
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Drain the block, then write the limit and read it back
	task automatic set_limit(input limit_t value);
		in_valid <= 1'b0;
		while (words_due != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		apb_access(1'b1, value);
		apb_access(1'b0, value);
	endtask

	initial begin
		limit_t plan [6];
		int     goal;
		int     p;
		int     r;
		plan[0] = 6'd0;
		plan[1] = 6'd63;
		plan[2] = 6'd1;
		plan[3] = 6'd32;
		plan[4] = limit_t'($urandom_range(0, 63));
		plan[5] = LIMIT_RESET;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words against the reset limit
		foreach (opening[k])
			send_char(opening[k][9], opening[k][8:1], opening[k][0]);

		// Random phases, each under its own limit; the last one without idling
		for (p = 0; p < 6; p++) begin
			set_limit(plan[p]);
			if (p == 5)
				idling = 1'b0;
			goal = requests_sent + 230;
			while (requests_sent < goal) begin
				r = $urandom_range(0, 19);
				if (r < 3 || query_word.size() == 0)
					send_query();
				else if (r < 18)
					send_candidate();
				else
					send_noise();
			end
		end

		in_valid <= 1'b0;
		while (words_due != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
		if (failures == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Guard against a hung block
	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
sv/wnmc_pkg.sv
sv/wnmc_ram.sv
sv/wnmc_engine.sv
sv/word_near_match_checker_top.sv
tb/word_match_monitor.sv
tb/tb.sv
